// File: rtl/cpid_pkg.sv
// ============================================================================
// cpid_pkg
// Shared constants, types and the microcode table of the cruise PID block.
// ============================================================================
package cpid_pkg;

	// Field widths fixed by the item formats.
	localparam int unsigned GainW     = 16;
	localparam int unsigned SpeedW    = 16;
	localparam int unsigned ThrW      = 12;
	localparam int unsigned SumW      = 22;
	localparam int unsigned DriveOutW = 12;
	localparam int unsigned FuncW     = 2;
	localparam int unsigned RegIdxW   = 2;

	// Default drive ceiling.
	localparam int unsigned MaxDriveDefault = 4095;

	// Integral clamp ceiling set by the width of the error sum.
	localparam logic [SumW-1:0] SumCeil = 22'h3F_FFFF;

	// Gain register reset values (gains are scaled by one thousand).
	localparam logic [GainW-1:0] KpReset = 16'd1000;
	localparam logic [GainW-1:0] KiReset = 16'd100;
	localparam logic [GainW-1:0] KdReset = 16'd800;

	// Term scaling: (k * v + 500) / 1000, truncated toward zero.
	localparam logic [9:0] Scale     = 10'd1000;
	localparam int unsigned MagW     = 33;   // bits of |k * v|
	localparam int unsigned RoundW   = 35;   // signed k * v + 500
	localparam int unsigned ShW      = 30;   // |k * v + 500| / 8
	// Division by 125 as a reciprocal multiply: ceil(2^37 / 125).
	localparam logic [30:0] RecipM   = 31'd1099511628;
	localparam int unsigned RecipSh  = 37;
	localparam int unsigned TermW    = 24;   // one scaled term, magnitude
	localparam int unsigned CvW      = 27;   // sum of three signed terms
	localparam int unsigned MulW     = 32;   // shared multiplier operands
	localparam int unsigned ProdW    = 61;   // widest product kept

	// Function codes carried in the input beat.
	typedef enum logic [FuncW-1:0] {
		FUNC_UPDATE,
		FUNC_ENGAGE,
		FUNC_REMOTE,
		FUNC_CLEAR
	} func_t;

	// Configuration register indexes.
	typedef enum logic [RegIdxW-1:0] {
		REG_GAIN_PROP,
		REG_GAIN_INTEGRAL,
		REG_GAIN_DERIV
	} reg_idx_t;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_LIM_DIV,
		UOP_WAIT,
		UOP_INTEG,
		UOP_MUL,
		UOP_ROUND,
		UOP_RECIP,
		UOP_ACCUM,
		UOP_CLAMP,
		UOP_THR_MUL,
		UOP_THR_DIV,
		UOP_THR_SET,
		UOP_REMOTE,
		UOP_CLEAR
	} uop_t;

	// Jump conditions of a control word.
	typedef enum logic [1:0] {
		COND_NONE,
		COND_DIV_BUSY,
		COND_MORE_TERMS
	} cond_t;

	// Program steps.
	localparam int unsigned StepW = 4;
	typedef logic [StepW-1:0] step_t;

	localparam step_t STEP_UPD_LIM   = 4'd0;
	localparam step_t STEP_UPD_WAIT  = 4'd1;
	localparam step_t STEP_UPD_INTEG = 4'd2;
	localparam step_t STEP_UPD_MUL   = 4'd3;
	localparam step_t STEP_UPD_ROUND = 4'd4;
	localparam step_t STEP_UPD_RECIP = 4'd5;
	localparam step_t STEP_UPD_ACCUM = 4'd6;
	localparam step_t STEP_UPD_CLAMP = 4'd7;
	localparam step_t STEP_ENG_MUL   = 4'd8;
	localparam step_t STEP_ENG_DIV   = 4'd9;
	localparam step_t STEP_ENG_WAIT  = 4'd10;
	localparam step_t STEP_ENG_SET   = 4'd11;
	localparam step_t STEP_REMOTE    = 4'd12;
	localparam step_t STEP_CLEAR     = 4'd13;
	localparam step_t STEP_NOP       = 4'd14;
	localparam step_t STEP_SPARE     = 4'd15;

	// One control word.
	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t jump;
		logic  last;
	} uword_t;

	// Sequencer commands to the datapath.
	typedef struct packed {
		uop_t op;
		logic load_item;
		logic out_load;
	} dp_ctrl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic div_busy;
		logic term_last;
		logic cruise;
	} dp_stat_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_OUT
	} seq_state_t;

	// Microcode table. A word jumps to its target when its condition holds,
	// otherwise it falls through to the next step; a last word ends the item.
	function automatic uword_t cpid_ucode(input step_t step);
		uword_t w;
		w.op   = UOP_NOP;
		w.cond = COND_NONE;
		w.jump = STEP_NOP;
		w.last = 1'b1;
		case (step)
			STEP_UPD_LIM: begin
				w.op = UOP_LIM_DIV; w.last = 1'b0;
			end
			STEP_UPD_WAIT: begin
				w.op = UOP_WAIT; w.cond = COND_DIV_BUSY; w.jump = STEP_UPD_WAIT;
				w.last = 1'b0;
			end
			STEP_UPD_INTEG: begin
				w.op = UOP_INTEG; w.last = 1'b0;
			end
			STEP_UPD_MUL: begin
				w.op = UOP_MUL; w.last = 1'b0;
			end
			STEP_UPD_ROUND: begin
				w.op = UOP_ROUND; w.last = 1'b0;
			end
			STEP_UPD_RECIP: begin
				w.op = UOP_RECIP; w.last = 1'b0;
			end
			STEP_UPD_ACCUM: begin
				w.op = UOP_ACCUM; w.cond = COND_MORE_TERMS; w.jump = STEP_UPD_MUL;
				w.last = 1'b0;
			end
			STEP_UPD_CLAMP: begin
				w.op = UOP_CLAMP;
			end
			STEP_ENG_MUL: begin
				w.op = UOP_THR_MUL; w.last = 1'b0;
			end
			STEP_ENG_DIV: begin
				w.op = UOP_THR_DIV; w.last = 1'b0;
			end
			STEP_ENG_WAIT: begin
				w.op = UOP_WAIT; w.cond = COND_DIV_BUSY; w.jump = STEP_ENG_WAIT;
				w.last = 1'b0;
			end
			STEP_ENG_SET: begin
				w.op = UOP_THR_SET;
			end
			STEP_REMOTE: begin
				w.op = UOP_REMOTE;
			end
			STEP_CLEAR: begin
				w.op = UOP_CLEAR;
			end
			STEP_NOP: begin
				w.op = UOP_NOP;
			end
			default: begin
				w.op = UOP_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/cpid_div.sv
// ============================================================================
// cpid_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ============================================================================
module cpid_div #(
	parameter int unsigned DIV_W = 26
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIV_W-1:0]              dividend,
	input  logic [cpid_pkg::GainW-1:0]    divisor,
	output logic                          busy,
	output logic [DIV_W-1:0]              quot
);

	localparam int unsigned CntW = $clog2(DIV_W + 1);

	logic [CntW-1:0]               cnt_q;
	logic [DIV_W-1:0]              quot_q;
	logic [cpid_pkg::GainW-1:0]    rem_q;
	logic [cpid_pkg::GainW-1:0]    dvs_q;
	logic [cpid_pkg::GainW:0]      trial;
	logic [cpid_pkg::GainW:0]      diff;
	logic                          fits;

	// Shift in the next dividend bit and try one subtraction.
	always_comb begin
		trial = {rem_q, quot_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[DIV_W-2:0], fits};
			rem_q  <= fits ? diff[cpid_pkg::GainW-1:0] : trial[cpid_pkg::GainW-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

	// A new division must not cut into one that is still running.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("divider restarted while busy");

endmodule

// File: rtl/cpid_dp.sv
// ============================================================================
// cpid_dp
// Controller datapath: gains, loop state, shared multiplier and divider.
// ============================================================================
module cpid_dp #(
	parameter int unsigned MAX_DRIVE = cpid_pkg::MaxDriveDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cpid_pkg::dp_ctrl_t                 ctrl,
	output cpid_pkg::dp_stat_t                 stat,
	input  logic signed [cpid_pkg::SpeedW-1:0] speed,
	input  logic [cpid_pkg::ThrW-1:0]          throttle,
	input  logic signed [cpid_pkg::SpeedW-1:0] remote_speed,
	input  logic                               cfg_we,
	input  logic [cpid_pkg::RegIdxW-1:0]       cfg_index,
	input  logic [cpid_pkg::GainW-1:0]         cfg_wdata,
	output logic [cpid_pkg::DriveOutW-1:0]     drive_level,
	output logic                               cruise_active,
	output logic signed [cpid_pkg::SpeedW-1:0] target_speed,
	output logic [cpid_pkg::SumW-1:0]          error_sum
);

	localparam int unsigned LimBits = $clog2(MAX_DRIVE * 1000 + 1);
	localparam int unsigned DIV_W   = (LimBits > cpid_pkg::SumW) ? LimBits : cpid_pkg::SumW;
	localparam int unsigned DrvBits = $clog2(MAX_DRIVE + 1);
	localparam int unsigned DRIVE_W =
		(DrvBits > cpid_pkg::DriveOutW) ? DrvBits : cpid_pkg::DriveOutW;
	localparam int unsigned VW      = cpid_pkg::SumW + 1;
	localparam int unsigned ErrW    = cpid_pkg::SpeedW + 1;
	localparam int unsigned IsumW   = cpid_pkg::SumW + 2;
	localparam int unsigned TermLast = 2;

	localparam logic [DIV_W-1:0]                LimNum  = DIV_W'(MAX_DRIVE * 1000);
	localparam logic [DRIVE_W-1:0]              MaxDrv  = DRIVE_W'(MAX_DRIVE);
	localparam logic signed [cpid_pkg::CvW-1:0] MaxCv   = cpid_pkg::CvW'(MAX_DRIVE);
	localparam logic signed [ErrW-1:0]          DeadLo  = -17'sd1;
	localparam logic signed [ErrW-1:0]          DeadHi  = 17'sd1;
	localparam logic signed [cpid_pkg::RoundW-1:0] Bias = 35'sd500;

	// Gains.
	logic [cpid_pkg::GainW-1:0] kp_q, ki_q, kd_q;

	// Loop state.
	logic signed [cpid_pkg::SpeedW-1:0] target_q, last_q;
	logic [cpid_pkg::SumW-1:0]          integ_q;
	logic [DRIVE_W-1:0]                 drive_q;
	logic                               cruise_q;

	// Item and working registers.
	logic signed [cpid_pkg::SpeedW-1:0] speed_q, rspd_q;
	logic [cpid_pkg::ThrW-1:0]          thr_q;
	logic signed [ErrW-1:0]             err_q, dspd_q;
	logic [cpid_pkg::SumW-1:0]          lim_q;
	logic [cpid_pkg::ProdW-1:0]         prod_q;
	logic                               neg_q, sgn_q;
	logic [cpid_pkg::ShW-1:0]           sh_q;
	logic signed [cpid_pkg::CvW-1:0]    cv_q;
	logic [1:0]                         term_q;

	// Output register.
	logic [cpid_pkg::DriveOutW-1:0]     out_drive_q;
	logic                               out_cruise_q;
	logic signed [cpid_pkg::SpeedW-1:0] out_target_q;
	logic [cpid_pkg::SumW-1:0]          out_sum_q;

	// Combinational helpers.
	logic signed [ErrW-1:0]             err_raw, err_dz, dspd_raw;
	logic signed [IsumW-1:0]            isum;
	logic [cpid_pkg::SumW-1:0]          integ_new;
	logic signed [VW-1:0]               v_sel;
	logic [VW-1:0]                      v_mag;
	logic [cpid_pkg::GainW-1:0]         k_sel;
	logic [cpid_pkg::MulW-1:0]          mul_a, mul_b;
	logic [2*cpid_pkg::MulW-1:0]        mul_p;
	logic signed [cpid_pkg::RoundW-1:0] p_sig, y_val, y_mag;
	logic [cpid_pkg::TermW-1:0]         term_mag;
	logic signed [cpid_pkg::CvW-1:0]    term_sig;
	logic                               div_start, div_busy;
	logic [DIV_W-1:0]                   div_num, div_quot;
	logic [cpid_pkg::GainW-1:0]         ki_eff;
	logic [cpid_pkg::SumW-1:0]          quot_cap;

	// Error with dead band, speed difference, and clamped error sum.
	always_comb begin
		err_raw  = {target_q[cpid_pkg::SpeedW-1], target_q} - {speed_q[cpid_pkg::SpeedW-1], speed_q};
		err_dz   = (err_raw >= DeadLo && err_raw <= DeadHi) ? '0 : err_raw;
		dspd_raw = {last_q[cpid_pkg::SpeedW-1], last_q} - {speed_q[cpid_pkg::SpeedW-1], speed_q};
		isum     = $signed({2'b00, integ_q}) + $signed({{(IsumW-ErrW){err_q[ErrW-1]}}, err_q});
		if (isum[IsumW-1]) begin
			integ_new = '0;
		end else if (isum[IsumW-2:0] > {1'b0, lim_q}) begin
			integ_new = lim_q;
		end else begin
			integ_new = isum[cpid_pkg::SumW-1:0];
		end
	end

	// Operand of the current term.
	always_comb begin
		case (term_q)
			2'd0: begin
				v_sel = {{(VW-ErrW){err_q[ErrW-1]}}, err_q};
				k_sel = kp_q;
			end
			2'd1: begin
				v_sel = {1'b0, integ_q};
				k_sel = ki_q;
			end
			default: begin
				v_sel = {{(VW-ErrW){dspd_q[ErrW-1]}}, dspd_q};
				k_sel = kd_q;
			end
		endcase
		v_mag = v_sel[VW-1] ? VW'(-v_sel) : VW'(v_sel);
	end

	// Shared multiplier.
	always_comb begin
		case (ctrl.op)
			cpid_pkg::UOP_MUL: begin
				mul_a = cpid_pkg::MulW'(v_mag);
				mul_b = cpid_pkg::MulW'(k_sel);
			end
			cpid_pkg::UOP_RECIP: begin
				mul_a = cpid_pkg::MulW'(sh_q);
				mul_b = cpid_pkg::MulW'(cpid_pkg::RecipM);
			end
			cpid_pkg::UOP_THR_MUL: begin
				mul_a = cpid_pkg::MulW'(thr_q);
				mul_b = cpid_pkg::MulW'(cpid_pkg::Scale);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Rounding bias, magnitude of the biased product, and the scaled term.
	always_comb begin
		p_sig    = $signed({2'b00, prod_q[cpid_pkg::MagW-1:0]});
		y_val    = (neg_q ? -p_sig : p_sig) + Bias;
		y_mag    = y_val[cpid_pkg::RoundW-1] ? -y_val : y_val;
		term_mag = prod_q[cpid_pkg::RecipSh +: cpid_pkg::TermW];
		term_sig = $signed({{(cpid_pkg::CvW-cpid_pkg::TermW){1'b0}}, term_mag});
	end

	// Divider operands: the integral limit or the engage preset.
	always_comb begin
		ki_eff    = (ki_q == '0) ? cpid_pkg::GainW'(1) : ki_q;
		div_start = (ctrl.op == cpid_pkg::UOP_LIM_DIV) || (ctrl.op == cpid_pkg::UOP_THR_DIV);
		div_num   = (ctrl.op == cpid_pkg::UOP_THR_DIV) ? prod_q[DIV_W-1:0] : LimNum;
		quot_cap  = (div_quot > DIV_W'(cpid_pkg::SumCeil)) ? cpid_pkg::SumCeil
			: div_quot[cpid_pkg::SumW-1:0];
	end

	cpid_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (ki_eff),
		.busy    (div_busy),
		.quot    (div_quot)
	);

	// Gain registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= cpid_pkg::KpReset;
			ki_q <= cpid_pkg::KiReset;
			kd_q <= cpid_pkg::KdReset;
		end else if (cfg_we) begin
			case (cpid_pkg::reg_idx_t'(cfg_index))
				cpid_pkg::REG_GAIN_PROP:     kp_q <= cfg_wdata;
				cpid_pkg::REG_GAIN_INTEGRAL: ki_q <= cfg_wdata;
				cpid_pkg::REG_GAIN_DERIV:    kd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Loop state and term counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			last_q   <= '0;
			integ_q  <= '0;
			drive_q  <= '0;
			cruise_q <= 1'b0;
			term_q   <= '0;
		end else begin
			case (ctrl.op)
				cpid_pkg::UOP_INTEG: begin
					integ_q <= integ_new;
					last_q  <= speed_q;
					term_q  <= '0;
				end
				cpid_pkg::UOP_ACCUM: begin
					term_q <= term_q + 1'b1;
				end
				cpid_pkg::UOP_CLAMP: begin
					if (cv_q[cpid_pkg::CvW-1]) begin
						drive_q <= '0;
					end else if (cv_q > MaxCv) begin
						drive_q <= MaxDrv;
					end else begin
						drive_q <= cv_q[DRIVE_W-1:0];
					end
				end
				cpid_pkg::UOP_THR_MUL: begin
					target_q <= speed_q;
					drive_q  <= DRIVE_W'(thr_q);
					cruise_q <= 1'b1;
				end
				cpid_pkg::UOP_THR_SET: begin
					integ_q <= quot_cap;
				end
				cpid_pkg::UOP_REMOTE: begin
					target_q <= rspd_q;
					cruise_q <= 1'b1;
				end
				cpid_pkg::UOP_CLEAR: begin
					target_q <= '0;
					integ_q  <= '0;
					drive_q  <= '0;
					cruise_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Item capture and working registers.
	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			speed_q <= speed;
			thr_q   <= throttle;
			rspd_q  <= remote_speed;
		end
		case (ctrl.op)
			cpid_pkg::UOP_LIM_DIV: begin
				err_q  <= err_dz;
				dspd_q <= dspd_raw;
			end
			cpid_pkg::UOP_INTEG: begin
				lim_q <= lim_q;
				cv_q  <= '0;
			end
			cpid_pkg::UOP_MUL: begin
				prod_q <= mul_p[cpid_pkg::ProdW-1:0];
				neg_q  <= v_sel[VW-1];
			end
			cpid_pkg::UOP_ROUND: begin
				sh_q  <= y_mag[cpid_pkg::MagW-1:3];
				sgn_q <= y_val[cpid_pkg::RoundW-1];
			end
			cpid_pkg::UOP_RECIP: begin
				prod_q <= mul_p[cpid_pkg::ProdW-1:0];
			end
			cpid_pkg::UOP_ACCUM: begin
				cv_q <= sgn_q ? cv_q - term_sig : cv_q + term_sig;
			end
			cpid_pkg::UOP_THR_MUL: begin
				prod_q <= mul_p[cpid_pkg::ProdW-1:0];
			end
			default: ;
		endcase
		// The limit is ready when the wait step sees the divider finish.
		if (ctrl.op == cpid_pkg::UOP_WAIT && !div_busy) begin
			lim_q <= quot_cap;
		end
	end

	// Result register, loaded when the finished beat is handed over.
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_drive_q  <= drive_q[cpid_pkg::DriveOutW-1:0];
			out_cruise_q <= cruise_q;
			out_target_q <= target_q;
			out_sum_q    <= integ_q;
		end
	end

	assign drive_level   = out_drive_q;
	assign cruise_active = out_cruise_q;
	assign target_speed  = out_target_q;
	assign error_sum     = out_sum_q;

	assign stat.div_busy  = div_busy;
	assign stat.term_last = term_q == 2'(TermLast);
	assign stat.cruise    = cruise_q;

	// The error sum stays within the limit computed for this update.
	a_integ_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == cpid_pkg::UOP_INTEG |=> integ_q <= lim_q)
		else $error("error sum above its limit after update");

	// A computed drive level never exceeds the drive ceiling.
	a_drive_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == cpid_pkg::UOP_CLAMP |=> drive_q <= MaxDrv)
		else $error("drive level above ceiling after update");

endmodule

// File: rtl/cpid_seq.sv
// ============================================================================
// cpid_seq
// Microcode sequencer: step counter, control word fetch, jumps, handshakes.
// ============================================================================
module cpid_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cpid_pkg::FuncW-1:0]    func,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  cpid_pkg::dp_stat_t            stat,
	output cpid_pkg::dp_ctrl_t            ctrl
);

	cpid_pkg::seq_state_t state_q, state_d;
	cpid_pkg::step_t      upc_q, upc_d, entry;
	cpid_pkg::uword_t     word;
	logic                 m_valid_q, m_valid_d;
	logic                 take;

	// Entry point of the program for the function code of the beat.
	always_comb begin
		case (cpid_pkg::func_t'(func))
			cpid_pkg::FUNC_UPDATE: entry = stat.cruise ? cpid_pkg::STEP_UPD_LIM
				: cpid_pkg::STEP_NOP;
			cpid_pkg::FUNC_ENGAGE: entry = cpid_pkg::STEP_ENG_MUL;
			cpid_pkg::FUNC_REMOTE: entry = cpid_pkg::STEP_REMOTE;
			cpid_pkg::FUNC_CLEAR:  entry = cpid_pkg::STEP_CLEAR;
			default:               entry = cpid_pkg::STEP_NOP;
		endcase
	end

	// Control word fetch and jump condition.
	always_comb begin
		word = cpid_pkg::cpid_ucode(upc_q);
		case (word.cond)
			cpid_pkg::COND_DIV_BUSY:   take = stat.div_busy;
			cpid_pkg::COND_MORE_TERMS: take = !stat.term_last;
			default:                   take = 1'b0;
		endcase
	end

	// Next state, step and datapath commands.
	always_comb begin
		state_d        = state_q;
		upc_d          = upc_q;
		m_valid_d      = m_valid_q && !m_tready;
		ctrl.op        = cpid_pkg::UOP_NOP;
		ctrl.load_item = 1'b0;
		ctrl.out_load  = 1'b0;
		case (state_q)
			cpid_pkg::SEQ_IDLE: begin
				if (s_tvalid) begin
					ctrl.load_item = 1'b1;
					upc_d          = entry;
					state_d        = cpid_pkg::SEQ_RUN;
				end
			end
			cpid_pkg::SEQ_RUN: begin
				ctrl.op = word.op;
				if (word.last) begin
					state_d = cpid_pkg::SEQ_OUT;
				end else if (take) begin
					upc_d = word.jump;
				end else begin
					upc_d = upc_q + 1'b1;
				end
			end
			cpid_pkg::SEQ_OUT: begin
				if (!m_valid_q || m_tready) begin
					ctrl.out_load = 1'b1;
					m_valid_d     = 1'b1;
					state_d       = cpid_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = cpid_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cpid_pkg::SEQ_IDLE;
			upc_q     <= cpid_pkg::STEP_NOP;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			upc_q     <= upc_d;
			m_valid_q <= m_valid_d;
		end
	end

	assign s_tready = state_q == cpid_pkg::SEQ_IDLE;
	assign m_tvalid = m_valid_q;

	// An accepted beat keeps the block busy until its result is handed over.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again before the result was delivered");

	// Handing over a result always leaves a valid output beat.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |=> m_tvalid)
		else $error("result loaded but not shown");

	// The program never runs into the unused step.
	a_no_spare_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cpid_pkg::SEQ_RUN |-> upc_q != cpid_pkg::STEP_SPARE)
		else $error("sequencer reached an unused step");

endmodule

// File: rtl/cruise_pid_controller.sv
// ============================================================================
// cruise_pid_controller
// Cruise-control PID with integral clamp, run by a microcoded sequencer.
// ============================================================================
// Use: each input beat carries a function code in s_tuser (update, engage,
// remote enable, clear) and speed, throttle and remote target in s_tdata.
// Every beat gives exactly one output beat with the drive level, the cruise
// flag, the target speed and the error sum as they stand after that beat.
// Gains are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, the block itself does not enforce it.
// Timing: a beat is taken when the block is idle. A speed update while
// cruising runs the serial divider that forms the integral limit (22
// quotient bits with the default drive ceiling, one per cycle) and then the
// three four-step passes of the shared multiplier; a larger ceiling adds
// quotient bits. An engage runs the same divider; the other beats use neither
// the divider nor the multiplier. A new beat is taken only after the result
// of the last one is loaded into the output register. The output register
// frees the input side: a new beat is accepted while the last result still
// waits, and only its own result waits for m_tready. Reset clears the loop
// state, sets the gains to their defaults and leaves the block idle with no
// output beat pending.
// ============================================================================
module cruise_pid_controller #(
	parameter int unsigned MAX_DRIVE = cpid_pkg::MaxDriveDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [47:0]                         s_tdata,  // speed, throttle, remote_speed, pad
	input  logic [cpid_pkg::FuncW-1:0]          s_tuser,  // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [55:0]                         m_tdata,  // drive_level, cruise_active,
	                                                      // target_speed, error_sum, pad
	input  logic                                cfg_we,
	input  logic [cpid_pkg::RegIdxW-1:0]        cfg_index,
	input  logic [cpid_pkg::GainW-1:0]          cfg_wdata
);

	cpid_pkg::dp_ctrl_t                 ctrl;
	cpid_pkg::dp_stat_t                 stat;
	logic [cpid_pkg::DriveOutW-1:0]     drive_level;
	logic                               cruise_active;
	logic signed [cpid_pkg::SpeedW-1:0] target_speed;
	logic [cpid_pkg::SumW-1:0]          error_sum;

	cpid_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.func    (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	cpid_dp #(
		.MAX_DRIVE(MAX_DRIVE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.speed        ($signed(s_tdata[15:0])),
		.throttle     (s_tdata[27:16]),
		.remote_speed ($signed(s_tdata[43:28])),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.drive_level  (drive_level),
		.cruise_active(cruise_active),
		.target_speed (target_speed),
		.error_sum    (error_sum)
	);

	// Pack the result beat, first field in the lowest bits.
	assign m_tdata = {5'b0, error_sum, target_speed, cruise_active, drive_level};

endmodule
